// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker in fpa_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while dis is true
`define AST_IMPLY(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while dis is true
`define AST_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NUM_CELLS = NUM_W;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_GT   = 4'd4;
  localparam logic [3:0] OP_GE   = 4'd5;
  localparam logic [3:0] OP_LT   = 4'd6;
  localparam logic [3:0] OP_LE   = 4'd7;
  localparam logic [3:0] OP_EQ   = 4'd8;
  localparam logic [3:0] OP_NE   = 4'd9;
  localparam logic [3:0] OP_MIN  = 4'd10;
  localparam logic [3:0] OP_MAX  = 4'd11;
  localparam logic [3:0] OP_INC  = 4'd12;
  localparam logic [3:0] OP_DEC  = 4'd13;
  localparam logic [3:0] OP_TOI  = 4'd14;
  localparam logic [3:0] OP_FROMI = 4'd15;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // one word as it travels down the divider chain
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic              cmp;
    logic [1:0]        st;
    logic [NUM_W-1:0]  acc;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dvs;
  } fpa_cell_t;

endpackage

// File: rtl/core/fpa_if.sv
`timescale 1ns / 1ps
interface fpa_in_if;
  logic                             valid;
  logic                             ready;
  logic [3:0]                       operation;
  logic signed [fpa_pkg::DATA_W-1:0] operand_a;
  logic signed [fpa_pkg::DATA_W-1:0] operand_b;
  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fpa_pkg::DATA_W-1:0] result_value;
  logic                             compare_true;
  logic [1:0]                       status;
  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink (input valid, result_value, compare_true, status, output ready);
endinterface

// File: rtl/core/fixed_point_q8_alu_unit.sv
`timescale 1ns / 1ps
// stages from accepted word to result: 2 front stages, 40 divider cells, output register
// throughput: one word per cycle while the pipe advances; one quotient bit per divider cell
// the whole pipe advances when the output register is empty or being taken
// reset: synchronous active-low rst_n clears all valid bits; payload is not reset
module fixed_point_q8_alu_unit (
  input  logic       clk,
  input  logic       rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);
  import fpa_pkg::*;

  logic      en;
  logic      out_valid;
  fpa_cell_t chain [NUM_CELLS+1];

  // global advance
  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  fpa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_take (in_ch.valid),
    .op_i    (in_ch.operation),
    .a_i     (in_ch.operand_a),
    .b_i     (in_ch.operand_b),
    .d_o     (chain[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (chain[i]),
      .d_o   (chain[i+1])
    );
  end

  fpa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .d_i     (chain[NUM_CELLS]),
    .valid_o (out_valid),
    .res_o   (out_ch.result_value),
    .cmp_o   (out_ch.compare_true),
    .st_o    (out_ch.status)
  );

  assign out_ch.valid = out_valid;
endmodule

// File: rtl/core/fpa_div_cell.sv
`timescale 1ns / 1ps
module fpa_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  fpa_pkg::fpa_cell_t d_i,
  output fpa_pkg::fpa_cell_t d_o
);
  import fpa_pkg::*;

  logic [DATA_W:0]   trial;
  logic              qbit;
  fpa_cell_t         cell_nxt;
  fpa_cell_t         cell_r;

  // one restoring division step: bring in the next numerator bit
  always_comb begin
    trial    = {d_i.rem, d_i.acc[NUM_W-1]};
    qbit     = (trial >= {1'b0, d_i.dvs});
    cell_nxt = d_i;
    cell_nxt.rem = qbit ? DATA_W'(trial - {1'b0, d_i.dvs}) : trial[DATA_W-1:0];
    cell_nxt.acc = {d_i.acc[NUM_W-2:0], qbit};
  end

  // valid cleared by reset, payload just follows the advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_o = cell_r;
endmodule

// File: rtl/core/fpa_front.sv
`timescale 1ns / 1ps
module fpa_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_take,
  input  logic [3:0]                op_i,
  input  logic [fpa_pkg::DATA_W-1:0] a_i,
  input  logic [fpa_pkg::DATA_W-1:0] b_i,
  output fpa_pkg::fpa_cell_t        d_o
);
  import fpa_pkg::*;

  logic                     v1_r;
  logic [3:0]               op1_r;
  logic [DATA_W-1:0]        a1_r;
  logic [DATA_W-1:0]        b1_r;
  logic signed [PROD_W-1:0] prod1_r;

  logic [DATA_W:0]   sum;
  logic [PROD_W-1:0] pmag;
  logic [PROD_W-1:0] prnd;
  logic              slt;
  logic              seq;
  logic [FRAC_BITS:0] top_a;
  fpa_cell_t         cell_nxt;
  fpa_cell_t         cell_r;

  // first stage: capture the word and form the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= op_i;
      a1_r    <= a_i;
      b1_r    <= b_i;
      prod1_r <= $signed(a_i) * $signed(b_i);
    end
  end

  // second stage: every operation but division, and the divider setup
  always_comb begin
    slt   = $signed(a1_r) < $signed(b1_r);
    seq   = (a1_r == b1_r);
    top_a = a1_r[DATA_W-1:DATA_W-1-FRAC_BITS];
    pmag  = prod1_r[PROD_W-1] ? PROD_W'(-prod1_r) : PROD_W'(prod1_r);
    prnd  = (pmag + PROD_W'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
    sum   = '0;

    cell_nxt        = '0;
    cell_nxt.valid  = v1_r;
    cell_nxt.st     = ST_OK;
    cell_nxt.neg    = a1_r[DATA_W-1] ^ b1_r[DATA_W-1];
    cell_nxt.acc    = {(a1_r[DATA_W-1] ? DATA_W'(-a1_r) : a1_r), {FRAC_BITS{1'b0}}};
    cell_nxt.dvs    = b1_r[DATA_W-1] ? DATA_W'(-b1_r) : b1_r;
    cell_nxt.rem    = '0;

    unique case (op1_r) inside
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        case (op1_r)
          OP_ADD:  sum = {a1_r[DATA_W-1], a1_r} + {b1_r[DATA_W-1], b1_r};
          OP_SUB:  sum = {a1_r[DATA_W-1], a1_r} - {b1_r[DATA_W-1], b1_r};
          OP_INC:  sum = {a1_r[DATA_W-1], a1_r} + (DATA_W+1)'(1);
          default: sum = {a1_r[DATA_W-1], a1_r} - (DATA_W+1)'(1);
        endcase
        if (sum[DATA_W] != sum[DATA_W-1]) begin
          cell_nxt.st  = ST_OVF;
          cell_nxt.res = sum[DATA_W] ? MIN_NEG : MAX_POS;
        end else begin
          cell_nxt.res = sum[DATA_W-1:0];
        end
      end
      OP_MUL: begin
        if (prod1_r[PROD_W-1] && prnd > PROD_W'(MIN_NEG)) begin
          cell_nxt.st  = ST_OVF;
          cell_nxt.res = MIN_NEG;
        end else if (!prod1_r[PROD_W-1] && prnd > PROD_W'(MAX_POS)) begin
          cell_nxt.st  = ST_OVF;
          cell_nxt.res = MAX_POS;
        end else begin
          cell_nxt.res = prod1_r[PROD_W-1] ? DATA_W'(-prnd) : prnd[DATA_W-1:0];
        end
      end
      OP_DIV: begin
        cell_nxt.is_div = (b1_r != '0);
        if (b1_r == '0) begin
          cell_nxt.st = ST_DIV0;
        end
      end
      OP_GT: cell_nxt.cmp = !slt && !seq;
      OP_GE: cell_nxt.cmp = !slt;
      OP_LT: cell_nxt.cmp = slt;
      OP_LE: cell_nxt.cmp = slt || seq;
      OP_EQ: cell_nxt.cmp = seq;
      OP_NE: cell_nxt.cmp = !seq;
      OP_MIN: cell_nxt.res = (!slt && !seq) ? b1_r : a1_r;
      OP_MAX: cell_nxt.res = slt ? b1_r : a1_r;
      OP_TOI: cell_nxt.res = DATA_W'($signed(a1_r) >>> FRAC_BITS);
      default: begin
        // from_int: saturate unless the top bits are all sign
        if (!(&top_a) && (|top_a)) begin
          cell_nxt.st  = ST_OVF;
          cell_nxt.res = a1_r[DATA_W-1] ? MIN_NEG : MAX_POS;
        end else begin
          cell_nxt.res = {a1_r[DATA_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        end
      end
    endcase
  end

  // valid cleared by reset, payload just follows the advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_o = cell_r;
endmodule

// File: rtl/core/fpa_back.sv
`timescale 1ns / 1ps
module fpa_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  fpa_pkg::fpa_cell_t        d_i,
  output logic                      valid_o,
  output logic [fpa_pkg::DATA_W-1:0] res_o,
  output logic                      cmp_o,
  output logic [1:0]                st_o
);
  import fpa_pkg::*;

  logic [NUM_W:0]    q;
  logic              rnd;
  logic [DATA_W-1:0] res_nxt;
  logic [1:0]        st_nxt;
  logic              valid_r;
  logic [DATA_W-1:0] res_r;
  logic              cmp_r;
  logic [1:0]        st_r;

  // quotient rounding and saturation
  always_comb begin
    rnd     = ({d_i.rem, 1'b0} >= {1'b0, d_i.dvs});
    q       = {1'b0, d_i.acc} + (NUM_W+1)'(rnd);
    res_nxt = d_i.res;
    st_nxt  = d_i.st;
    if (d_i.is_div) begin
      if (d_i.neg && q > (NUM_W+1)'(MIN_NEG)) begin
        res_nxt = MIN_NEG;
        st_nxt  = ST_OVF;
      end else if (!d_i.neg && q > (NUM_W+1)'(MAX_POS)) begin
        res_nxt = MAX_POS;
        st_nxt  = ST_OVF;
      end else begin
        res_nxt = d_i.neg ? DATA_W'(-q) : q[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      cmp_r <= d_i.cmp;
      st_r  <= st_nxt;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;
  assign cmp_o   = cmp_r;
  assign st_o    = st_r;
endmodule

// File: rtl/core/fpa_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fpa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [fpa_pkg::DATA_W-1:0] out_result,
  input logic                      out_cmp,
  input logic [1:0]                out_status
);
  import fpa_pkg::*;

  // a stalled result stays offered
  `AST_NEXT(a_hold, clk, !rst_n, out_valid && !out_ready, out_valid)
  // a true comparison carries a zero value and ok status
  `AST_IMPLY(a_cmp, clk, !rst_n, out_valid && out_cmp, out_result == '0 && out_status == ST_OK)
  // status code three never appears
  `AST_IMPLY(a_st, clk, !rst_n, out_valid, out_status != 2'd3)
  // no result right after reset
  `AST_NEXT(a_rst, clk, 1'b0, !rst_n, !out_valid)
  // input is refused only while a result stalls
  `AST_IMPLY(a_rdy, clk, !rst_n, !in_ready, out_valid && !out_ready)
endmodule

bind fixed_point_q8_alu_unit fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result_value),
  .out_cmp    (out_ch.compare_true),
  .out_status (out_ch.status)
);

// File: verif/fixed_point_q8_alu_unit_tb.sv
`timescale 1ns / 1ps
module fixed_point_q8_alu_unit_tb;
  import fpa_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     flag;
    logic [1:0]               st;
  } alu_result_t;

  logic clk;
  logic rst_n;
  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_q8_alu_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  alu_result_t expected_results[$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("fixed_point_q8_alu_unit verification failed");
      $finish;
    end
  end

  // saturate a wide value to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] clamp_word(input logic signed [95:0] v,
                                                          inout logic [1:0] st);
    if (v > 96'sd2147483647) begin
      st = ST_OVF;
      return MAX_POS;
    end
    if (v < -96'sd2147483648) begin
      st = ST_OVF;
      return MIN_NEG;
    end
    return v[DATA_W-1:0];
  endfunction

  // exact fixed-point result for one word
  function automatic alu_result_t alu_predict(input logic [3:0] op,
                                              input logic signed [DATA_W-1:0] a,
                                              input logic signed [DATA_W-1:0] b);
    alu_result_t r;
    logic signed [95:0] wa;
    logic signed [95:0] wb;
    logic signed [95:0] prod;
    logic [95:0] mag;
    logic [95:0] num;
    logic [95:0] den;
    logic [95:0] quo;
    logic [1:0] st;
    wa = a;
    wb = b;
    st = ST_OK;
    r = '0;
    case (op)
      OP_ADD: r.value = clamp_word(wa + wb, st);
      OP_SUB: r.value = clamp_word(wa - wb, st);
      OP_MUL: begin
        prod = wa * wb;
        mag = prod < 0 ? -prod : prod;
        mag = (mag + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r.value = clamp_word(prod < 0 ? -$signed(mag) : $signed(mag), st);
      end
      OP_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
        end else begin
          num = (wa < 0 ? -wa : wa) << FRAC_BITS;
          den = wb < 0 ? -wb : wb;
          quo = (2 * num + den) / (2 * den);
          r.value = clamp_word(((a < 0) != (b < 0)) ? -$signed(quo) : $signed(quo), st);
        end
      end
      OP_GT: r.flag = a > b;
      OP_GE: r.flag = a >= b;
      OP_LT: r.flag = a < b;
      OP_LE: r.flag = a <= b;
      OP_EQ: r.flag = a == b;
      OP_NE: r.flag = a != b;
      OP_MIN: r.value = (a > b) ? b : a;
      OP_MAX: r.value = (a < b) ? b : a;
      OP_INC: r.value = clamp_word(wa + 1, st);
      OP_DEC: r.value = clamp_word(wa - 1, st);
      OP_TOI: r.value = a >>> FRAC_BITS;
      default: r.value = clamp_word(wa <<< FRAC_BITS, st);
    endcase
    r.st = st;
    return r;
  endfunction

  // send one word and queue its expected result
  task automatic send_word(input logic [3:0] op, input logic signed [DATA_W-1:0] a,
                           input logic signed [DATA_W-1:0] b);
    // sender idle cycles
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(alu_predict(op, a, b));
    words_sent++;
    @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_ch.result_value);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        words_checked++;
        if (out_ch.result_value !== exp_r.value || out_ch.compare_true !== exp_r.flag ||
            out_ch.status !== exp_r.st) begin
          $display("%0t mismatch: expected %h/%b/%0d actual %h/%b/%0d", $time,
                   exp_r.value, exp_r.flag, exp_r.st, out_ch.result_value,
                   out_ch.compare_true, out_ch.status);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(7))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return $urandom_range(1024) - 512;
      3: return $signed($urandom) >>> $urandom_range(31);
      4: return 0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_edges();
    logic signed [DATA_W-1:0] vals[5];
    vals = '{MAX_POS, MIN_NEG, 0, 1, -1};
    for (int op = 0; op < 16; op++) send_word(4'(op), vals[op % 5], vals[(op + 2) % 5]);
    send_word(OP_DIV, 32'sd100, 32'sd0);
    send_word(OP_DIV, 32'sd3, 32'sd2048);
    send_word(OP_DIV, -32'sd3, 32'sd2048);
    send_word(OP_MUL, 32'sd128, 32'sd1);
    send_word(OP_MUL, -32'sd128, 32'sd1);
    send_word(OP_INC, MAX_POS, 32'sd0);
    send_word(OP_DEC, MIN_NEG, 32'sd0);
    send_word(OP_FROMI, MIN_NEG, 32'sd0);
    send_word(OP_EQ, 32'sd7, 32'sd7);
  endtask

  task automatic test_random(input int unsigned count);
    for (int i = 0; i < count; i++)
      send_word(4'($urandom_range(15)), pick_operand(), pick_operand());
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    cycle_count = 0;
    send_idle_pct = 15;
    recv_idle_pct = 51;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_edges();
    test_random(410);
    send_idle_pct = 51;
    recv_idle_pct = 15;
    test_random(410);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(410);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d words over all sixteen operations, checked %0d results",
             words_sent, words_checked);
    $display("covered saturation, divide by zero and rounding ties under stalls");
    if (errors == 0) begin
      $display("fixed_point_q8_alu_unit verification clean");
    end else begin
      $display("fixed_point_q8_alu_unit verification failed");
    end
    $finish;
  end
endmodule
